// ===== hw/rtl/interpolated_band_check_assert.svh =====
// Assertion macros for the interpolated band check
`ifndef INTERPOLATED_BAND_CHECK_ASSERT_SVH
`define INTERPOLATED_BAND_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define IBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibc assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define IBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibc assertion failed");

`endif

// ===== hw/rtl/ibc_pkg.sv =====
package ibc_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRIT    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam int DIV_STEPS = 32;

    typedef struct packed {
        cmd_t               command;
        logic        [31:0] row_time;
        logic signed [31:0] row_lower;
        logic signed [31:0] row_upper;
        logic        [31:0] query_time;
        logic signed [31:0] sample;
        logic               sample_missing;
    } in_word_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic               bounds_valid;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
        logic               append_rejected;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ADDR,
        S_CMP,
        S_RESOLVE,
        S_FETCH1,
        S_FETCH2,
        S_CALC,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_CLASSIFY,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/ibc_ram.sv =====
module ibc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/ibc_div.sv =====
// restoring divider, one quotient bit per cycle; needs dividend[63:32] < divisor
module ibc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [31:0] div_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = 6'(ibc_pkg::DIV_STEPS);
            rem_next = dividend[63:32];
            quo_next = dividend[31:0];
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next  = cnt_reg - 6'd1;
            rem_next  = fits ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            quo_next  = {quo_reg[30:0], fits};
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/interpolated_band_check.sv =====
// Clear, append and no-op words, and queries on an empty table, go from accept through S_EXEC to S_DONE.
// Query: a binary search with states S_ADDR and S_CMP per step (one table read each step),
// then two row fetches and interpolation, with the 32-step serial divider run once per bound.
// One word is in work at a time; a finished result waits in the output register.
// Reset clears the row count, follow_reg and handshake state; table memories
// are not cleared.
module interpolated_band_check #(
    parameter int TABLE_ROWS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  ibc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output ibc_pkg::out_word_t out_word
);

    localparam int AW = $clog2(TABLE_ROWS);
    localparam int CW = $clog2(TABLE_ROWS + 1);

    ibc_pkg::state_t    state_reg;
    ibc_pkg::state_t    state_next;
    ibc_pkg::in_word_t  item_reg;
    ibc_pkg::out_word_t res_reg;
    ibc_pkg::out_word_t out_reg;
    logic               out_valid_reg;
    logic               follow_reg;
    logic [CW-1:0]      count_reg;
    logic [31:0]        last_time_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      mid_reg;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      prev_idx;
    logic [31:0]        t1_reg;
    logic [31:0]        l1_reg;
    logic [31:0]        u1_reg;
    logic [31:0]        dt_reg;
    logic [31:0]        span_reg;
    logic [31:0]        mag_lo_reg;
    logic [31:0]        mag_hi_reg;
    logic               neg_lo_reg;
    logic               neg_hi_reg;
    logic               sel_reg;
    logic [63:0]        prod_reg;
    logic [32:0]        diff_lo;
    logic [32:0]        diff_hi;
    logic [32:0]        interp;
    logic               reject;
    logic               accept;
    logic               load_out;
    logic               ram_we;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        t_q;
    logic [31:0]        l_q;
    logic [31:0]        u_q;
    logic               div_start;
    logic               div_done;
    logic [31:0]        quotient;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ibc_pkg::S_IDLE);
    assign load_out = (state_reg == ibc_pkg::S_DONE) && (!out_valid_reg || !out_stall);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign prev_idx = lo_reg - CW'(1);
    assign reject   = (count_reg == CW'(TABLE_ROWS))
                   || ((count_reg != '0) && (item_reg.row_time <= last_time_reg));

    assign diff_lo = {l_q[31], l_q} - {l1_reg[31], l1_reg};
    assign diff_hi = {u_q[31], u_q} - {u1_reg[31], u1_reg};
    assign interp  = sel_reg
        ? (neg_hi_reg ? {u1_reg[31], u1_reg} - {1'b0, quotient}
                      : {u1_reg[31], u1_reg} + {1'b0, quotient})
        : (neg_lo_reg ? {l1_reg[31], l1_reg} - {1'b0, quotient}
                      : {l1_reg[31], l1_reg} + {1'b0, quotient});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ibc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ibc_pkg::S_EXEC;
                end
            end
            ibc_pkg::S_EXEC:
            begin
                if (item_reg.command == ibc_pkg::CMD_QUERY && count_reg != '0)
                begin
                    state_next = ibc_pkg::S_ADDR;
                end
                else
                begin
                    state_next = ibc_pkg::S_DONE;
                end
            end
            ibc_pkg::S_ADDR:
            begin
                state_next = (lo_reg < hi_reg) ? ibc_pkg::S_CMP : ibc_pkg::S_RESOLVE;
            end
            ibc_pkg::S_CMP:       state_next = ibc_pkg::S_ADDR;
            ibc_pkg::S_RESOLVE:
            begin
                if (lo_reg == '0 || lo_reg >= count_reg)
                begin
                    state_next = ibc_pkg::S_DONE;
                end
                else
                begin
                    state_next = ibc_pkg::S_FETCH1;
                end
            end
            ibc_pkg::S_FETCH1:    state_next = ibc_pkg::S_FETCH2;
            ibc_pkg::S_FETCH2:    state_next = ibc_pkg::S_CALC;
            ibc_pkg::S_CALC:      state_next = ibc_pkg::S_MUL;
            ibc_pkg::S_MUL:       state_next = ibc_pkg::S_DIV_START;
            ibc_pkg::S_DIV_START: state_next = ibc_pkg::S_DIV_WAIT;
            ibc_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = sel_reg ? ibc_pkg::S_CLASSIFY : ibc_pkg::S_MUL;
                end
            end
            ibc_pkg::S_CLASSIFY:  state_next = ibc_pkg::S_DONE;
            ibc_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    state_next = ibc_pkg::S_IDLE;
                end
            end
            default:              state_next = ibc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        div_start = 1'b0;
        rd_addr   = mid[AW-1:0];
        case (state_reg)
            ibc_pkg::S_EXEC:
            begin
                ram_we = (item_reg.command == ibc_pkg::CMD_APPEND) && !reject;
            end
            ibc_pkg::S_FETCH1:    rd_addr = prev_idx[AW-1:0];
            ibc_pkg::S_FETCH2:    rd_addr = lo_reg[AW-1:0];
            ibc_pkg::S_DIV_START: div_start = 1'b1;
            default:              rd_addr = mid[AW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            follow_reg    <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                follow_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ibc_pkg::S_EXEC)
            begin
                if (item_reg.command == ibc_pkg::CMD_CLEAR)
                begin
                    count_reg <= '0;
                end
                else if (ram_we)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_word;
        end
        if (load_out)
        begin
            out_reg <= res_reg;
        end
        case (state_reg)
            ibc_pkg::S_EXEC:
            begin
                res_reg <= ibc_pkg::out_word_t'(
                    {67'd0, (item_reg.command == ibc_pkg::CMD_APPEND) && reject});
                lo_reg  <= '0;
                hi_reg  <= count_reg;
                if (ram_we)
                begin
                    last_time_reg <= item_reg.row_time;
                end
            end
            ibc_pkg::S_ADDR:
            begin
                mid_reg <= mid;
            end
            ibc_pkg::S_CMP:
            begin
                if (t_q > item_reg.query_time)
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg + CW'(1);
                end
            end
            ibc_pkg::S_RESOLVE:
            begin
                res_reg.status <= ibc_pkg::ST_UNKNOWN;
                sel_reg        <= 1'b0;
            end
            ibc_pkg::S_FETCH2:
            begin
                t1_reg <= t_q;
                l1_reg <= l_q;
                u1_reg <= u_q;
            end
            ibc_pkg::S_CALC:
            begin
                dt_reg     <= item_reg.query_time - t1_reg;
                span_reg   <= t_q - t1_reg;
                neg_lo_reg <= diff_lo[32];
                neg_hi_reg <= diff_hi[32];
                mag_lo_reg <= diff_lo[32] ? 32'(-diff_lo) : diff_lo[31:0];
                mag_hi_reg <= diff_hi[32] ? 32'(-diff_hi) : diff_hi[31:0];
            end
            ibc_pkg::S_MUL:
            begin
                prod_reg <= 64'(sel_reg ? mag_hi_reg : mag_lo_reg) * 64'(dt_reg);
            end
            ibc_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (sel_reg)
                    begin
                        res_reg.high_bound <= interp[31:0];
                    end
                    else
                    begin
                        res_reg.low_bound <= interp[31:0];
                    end
                    sel_reg <= 1'b1;
                end
            end
            ibc_pkg::S_CLASSIFY:
            begin
                res_reg.bounds_valid <= 1'b1;
                if (!follow_reg)
                begin
                    res_reg.status <= ibc_pkg::ST_OK;
                end
                else if (item_reg.sample_missing)
                begin
                    res_reg.status <= ibc_pkg::ST_UNKNOWN;
                end
                else if ($signed(item_reg.sample) >= $signed(res_reg.low_bound)
                      && $signed(item_reg.sample) <= $signed(res_reg.high_bound))
                begin
                    res_reg.status <= ibc_pkg::ST_OK;
                end
                else
                begin
                    res_reg.status <= ibc_pkg::ST_CRIT;
                end
            end
            default:
            begin
            end
        endcase
    end

    ibc_ram #(.WIDTH(32), .DEPTH(TABLE_ROWS)) u_times (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item_reg.row_time),
        .rd_addr (rd_addr),
        .rd_data (t_q)
    );

    ibc_ram #(.WIDTH(32), .DEPTH(TABLE_ROWS)) u_lowers (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item_reg.row_lower),
        .rd_addr (rd_addr),
        .rd_data (l_q)
    );

    ibc_ram #(.WIDTH(32), .DEPTH(TABLE_ROWS)) u_uppers (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item_reg.row_upper),
        .rd_addr (rd_addr),
        .rd_data (u_q)
    );

    ibc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ===== hw/rtl/ibc_checker.sv =====
`include "interpolated_band_check_assert.svh"

module ibc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input ibc_pkg::out_word_t out_word
);

    logic bounds_zero;
    logic reject_plain;

    assign bounds_zero  = (out_word.low_bound == 32'sd0) && (out_word.high_bound == 32'sd0);
    assign reject_plain = (out_word.status == ibc_pkg::ST_OK) && !out_word.bounds_valid;

    `IBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `IBC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word))
    `IBC_ASSERT_NOW(a_no_bounds_zero, out_valid && !out_word.bounds_valid, bounds_zero)
    `IBC_ASSERT_NOW(a_reject_plain, out_valid && out_word.append_rejected, reject_plain)

endmodule

bind interpolated_band_check ibc_checker u_ibc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

// ===== tb/interpolated_band_check_checker.sv =====
module interpolated_band_check_checker #(
    parameter int TABLE_ROWS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ibc_pkg::in_word_t  in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ibc_pkg::out_word_t out_word,
    output int                 fails,
    output int                 outstanding
);

    logic [31:0]        row_times  [TABLE_ROWS];
    logic [31:0]        row_lowers [TABLE_ROWS];
    logic [31:0]        row_uppers [TABLE_ROWS];
    int                 rows;
    logic               follow;
    ibc_pkg::out_word_t band_results[$];

    function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b,
                                         logic [31:0] dt, logic [31:0] span);
        longint      d1;
        longint      d2;
        longint      diff;
        logic [63:0] mag;
        logic [63:0] quo;
        d1   = longint'($signed(a));
        d2   = longint'($signed(b));
        diff = d2 - d1;
        mag  = (diff < 0) ? -diff : diff;
        quo  = (mag * {32'b0, dt}) / {32'b0, span};
        return (diff < 0) ? 32'(d1 - longint'(quo)) : 32'(d1 + longint'(quo));
    endfunction

    function automatic ibc_pkg::out_word_t classify(ibc_pkg::in_word_t w);
        ibc_pkg::out_word_t r;
        int                 lo_i;
        int                 hi_i;
        int                 mid;
        longint             s;
        r = '0;
        case (w.command)
            ibc_pkg::CMD_CLEAR: rows = 0;
            ibc_pkg::CMD_APPEND:
            begin
                if (rows >= TABLE_ROWS || (rows > 0 && w.row_time <= row_times[rows-1]))
                    r.append_rejected = 1'b1;
                else
                begin
                    row_times[rows]  = w.row_time;
                    row_lowers[rows] = w.row_lower;
                    row_uppers[rows] = w.row_upper;
                    rows++;
                end
            end
            ibc_pkg::CMD_QUERY:
            begin
                if (rows > 0)
                begin
                    lo_i = 0;
                    hi_i = rows;
                    while (lo_i < hi_i)
                    begin
                        mid = lo_i + (hi_i - lo_i) / 2;
                        if (row_times[mid] > w.query_time)
                            hi_i = mid;
                        else
                            lo_i = mid + 1;
                    end
                    if (lo_i == 0 || lo_i >= rows)
                        r.status = ibc_pkg::ST_UNKNOWN;
                    else
                    begin
                        r.low_bound  = lerp(row_lowers[lo_i-1], row_lowers[lo_i],
                                            w.query_time - row_times[lo_i-1],
                                            row_times[lo_i] - row_times[lo_i-1]);
                        r.high_bound = lerp(row_uppers[lo_i-1], row_uppers[lo_i],
                                            w.query_time - row_times[lo_i-1],
                                            row_times[lo_i] - row_times[lo_i-1]);
                        r.bounds_valid = 1'b1;
                        if (follow)
                        begin
                            s = longint'(w.sample);
                            if (w.sample_missing)
                                r.status = ibc_pkg::ST_UNKNOWN;
                            else if (s >= longint'(r.low_bound)
                                     && s <= longint'(r.high_bound))
                                r.status = ibc_pkg::ST_OK;
                            else
                                r.status = ibc_pkg::ST_CRIT;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ibc_pkg::out_word_t e;
        if (!rst_n)
        begin
            rows = 0;
            follow = 1'b0;
            band_results.delete();
            fails = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                follow = cfg_data;
            if (in_valid && !in_stall)
            begin
                band_results.push_back(classify(in_word));
                outstanding++;
            end
            if (out_valid && !out_stall)
            begin
                if (band_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word %h", out_word);
                end
                else
                begin
                    e = band_results.pop_front();
                    outstanding--;
                    if (e.status !== out_word.status || e.bounds_valid !== out_word.bounds_valid
                        || e.low_bound !== out_word.low_bound
                        || e.high_bound !== out_word.high_bound
                        || e.append_rejected !== out_word.append_rejected)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: exp st=%0d bv=%b lo=%h hi=%h rej=%b, ",
                                      "got st=%0d bv=%b lo=%h hi=%h rej=%b"},
                                     e.status, e.bounds_valid, e.low_bound, e.high_bound,
                                     e.append_rejected, out_word.status, out_word.bounds_valid,
                                     out_word.low_bound, out_word.high_bound,
                                     out_word.append_rejected);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_interpolated_band_check.sv =====
module tb_interpolated_band_check;

    localparam int CYCLE_LIMIT = 3000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_data;
    logic               in_valid;
    logic               in_stall;
    ibc_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    ibc_pkg::out_word_t out_word;
    logic               quiet;
    int                 fails;
    int                 outstanding;
    int                 cycles;

    logic [31:0] first_t;
    logic [31:0] last_t;
    logic [31:0] last_lo;
    logic [31:0] last_hi;
    int          rows;

    interpolated_band_check uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    interpolated_band_check_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word),
        .fails       (fails),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 29);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL interpolated_band_check");
            $finish;
        end
    end

    task automatic send(ibc_pkg::cmd_t c, logic [31:0] t, logic [31:0] lo, logic [31:0] hi,
                        logic [31:0] qt, logic [31:0] s, logic miss);
        ibc_pkg::in_word_t w;
        logic              ok;
        w = '{command: c, row_time: t, row_lower: lo, row_upper: hi,
              query_time: qt, sample: s, sample_missing: miss};
        if (!quiet && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end
        while (!ok);
        if (c == ibc_pkg::CMD_CLEAR)
            rows = 0;
        else if (c == ibc_pkg::CMD_APPEND && rows < 1024 && (rows == 0 || t > last_t))
        begin
            if (rows == 0)
                first_t = t;
            last_t  = t;
            last_lo = lo;
            last_hi = hi;
            rows++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic set_follow(logic v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_word();
        int          r;
        logic [31:0] t;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] qt;
        logic [31:0] s;
        logic [32:0] sum;
        r  = $urandom_range(99);
        lo = ($urandom_range(1)) ? $urandom : $signed($urandom_range(0, 2000)) - 1000;
        hi = ($urandom_range(3) == 0) ? $urandom : lo + $urandom_range(0, 1 << 20);
        if (r < 4)
            send(ibc_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(1) != 0);
        else if (r < 8)
            send(ibc_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(1) != 0);
        else if (r < 45)
        begin
            if (rows == 0)
                t = $urandom_range(1) ? $urandom_range(0, 1000) : $urandom;
            else if ($urandom_range(99) < 10)
                t = $urandom_range(0, last_t);
            else
                case ($urandom_range(3))
                    0: t = last_t + 1;
                    1: t = last_t + $urandom_range(1, 100);
                    2: t = last_t + $urandom_range(1, 1 << 20);
                    default: t = last_t + $urandom;
                endcase
            send(ibc_pkg::CMD_APPEND, t, lo, hi, $urandom, $urandom, $urandom_range(1) != 0);
        end
        else
        begin
            if (rows >= 2 && $urandom_range(99) < 80)
                qt = first_t + $urandom_range(0, last_t - first_t);
            else
                case ($urandom_range(3))
                    0: qt = last_t;
                    1: qt = first_t - 1;
                    default: qt = $urandom;
                endcase
            sum = {last_lo[31], last_lo} + {last_hi[31], last_hi};
            case ($urandom_range(4))
                0: s = last_lo;
                1: s = last_hi;
                2: s = sum[32:1];
                3: s = last_lo - 1;
                default: s = $urandom;
            endcase
            send(ibc_pkg::CMD_QUERY, $urandom, $urandom, $urandom, qt, s,
                 $urandom_range(9) == 0);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_stall = 1'b0;
        quiet     = 1'b0;
        cycles    = 0;
        rows      = 0;
        first_t   = '0;
        last_t    = '0;
        last_lo   = '0;
        last_hi   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        set_follow(1'b1);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 32'h1234, 32'h7fffffff, 1'b0);
        send(ibc_pkg::CMD_NOP, '1, '1, '1, '1, '1, 1'b1);
        send(ibc_pkg::CMD_APPEND, 0, 32'h80000000, 32'h7fffffff, 0, 0, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 1'b0);
        send(ibc_pkg::CMD_APPEND, 0, 1, 2, 0, 0, 1'b0);
        send(ibc_pkg::CMD_APPEND, 100, 32'h7fffffff, 32'h80000000, 0, 0, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 50, 0, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 99, 0, 1'b1);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 100, 0, 1'b0);
        send(ibc_pkg::CMD_APPEND, '1, 5, -5, 0, 0, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 200, 32'h7fffffff, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 32'hfffffffe, 32'h80000000, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, '1, 0, 1'b0);
        send(ibc_pkg::CMD_APPEND, '1, 0, 0, 0, 0, 1'b0);
        send(ibc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 50, 0, 1'b1);
        send(ibc_pkg::CMD_APPEND, 1000, -(100 << 16), 100 << 16, 0, 0, 1'b0);
        send(ibc_pkg::CMD_APPEND, 2000, 0, 200 << 16, 0, 0, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 1500, -(50 << 16), 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 1500, 150 << 16, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 1500, (150 << 16) + 1, 1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 1999, -(50 << 16) - 1, 1'b0);
        set_follow(1'b0);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 1500, 0, 1'b1);
        send(ibc_pkg::CMD_QUERY, 0, 0, 0, 999, 0, 1'b0);

        // a longer table for the search
        send(ibc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0);
        for (int i = 0; i < 40; i++)
            send(ibc_pkg::CMD_APPEND, i * 3 + 7, $urandom, $urandom, 0, 0, 1'b0);
        set_follow(1'b1);
        for (int i = 0; i < 8; i++)
            send(ibc_pkg::CMD_QUERY, 0, 0, 0, $urandom_range(0, 130), $urandom, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_follow(ph[0]);
            for (int i = 0; i < 80; i++)
            begin
                quiet = (ph == 2 && i >= 20 && i < 60);
                random_word();
            end
            quiet = 1'b0;
        end

        drain();
        repeat (200) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("PASS interpolated_band_check");
        else
            $display("FAIL interpolated_band_check");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ibc_pkg.sv
hw/rtl/ibc_ram.sv
hw/rtl/ibc_div.sv
hw/rtl/interpolated_band_check.sv
hw/rtl/ibc_checker.sv
tb/interpolated_band_check_checker.sv
tb/tb_interpolated_band_check.sv
